@@ rtl/core/deq_pkg.sv @@
// deq_pkg: shared types and constants for the double-ended queue core
// depends on nothing; imported by deq_cell and double_ended_queue_core
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 5;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    // request selector
    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_PEEK       = 3'd5
    } op_t;

    // result status
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // broadcast to every cell; moves are already gated by full and empty
    typedef struct packed {
        logic              push_front;
        logic              push_rear;
        logic              pop_front;
        logic              pop_rear;
        logic              clear;
        logic [WORD_W-1:0] word;
    } cell_ctrl_t;

endpackage

@@ rtl/core/deq_cell.sv @@
// deq_cell: one slot of the queue, holds a word and an occupied flag
// depends on deq_pkg (cell_ctrl_t, WORD_W)
module deq_cell
    import deq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic              left_valid,
    input  logic [WORD_W-1:0] left_data,
    input  logic              right_valid,
    input  logic [WORD_W-1:0] right_data,
    output logic              valid,
    output logic [WORD_W-1:0] data
);

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.push_front)
        begin
            // whole row moves one place toward the rear
            valid_next = left_valid;
            data_next  = left_data;
        end
        else if (ctrl.pop_front)
        begin
            // whole row moves one place toward the front
            valid_next = right_valid;
            data_next  = right_data;
        end
        else if (ctrl.push_rear)
        begin
            // first free slot takes the word
            if (!valid_reg && left_valid)
            begin
                valid_next = 1'b1;
                data_next  = ctrl.word;
            end
        end
        else if (ctrl.pop_rear)
        begin
            // last occupied slot lets go
            if (valid_reg && !right_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ rtl/core/double_ended_queue_core.sv @@
// double_ended_queue_core: bounded deque of signed words as a row of shifting cells
// depends on deq_pkg and deq_cell
//
//  channel   dir  width  contents
//  s_tdata   in   32     data_in
//  s_tuser   in   3      func
//  m_tdata   out  112    popped_value, front_value, rear_value, is_empty,
//                        is_full, occupancy, status
//
// one request per cycle: the cell row updates at the edge that takes the beat
// and the result is read straight off the cells and the status registers
// a new beat is taken while the result waits only if that result leaves in the
// same cycle, so a stalled result holds the whole row still
// reset clears all occupied flags, the count and the result valid; no sweep
module double_ended_queue_core
    import deq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [WORD_W-1:0]   s_tdata,   // [31:0] data_in
    input  logic [FUNC_W-1:0]   s_tuser,   // [2:0] func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [111:0]        m_tdata    // [31:0] popped_value, [63:32] front_value,
                                           // [95:64] rear_value, [96] is_empty,
                                           // [97] is_full, [102:98] occupancy,
                                           // [104:103] status, [111:105] zero
);

    // cell row
    logic              cell_valid [DEPTH];
    logic [WORD_W-1:0] cell_data  [DEPTH];
    cell_ctrl_t        ctrl;

    // control and result registers
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    status_t           status_reg;
    status_t           status_next;
    logic [WORD_W-1:0] popped_reg;
    logic [WORD_W-1:0] popped_next;

    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic [WORD_W-1:0] front_word;
    logic [WORD_W-1:0] rear_word;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // front is cell 0, rear is the last occupied cell
    always_comb
    begin
        front_word = cell_valid[0] ? cell_data[0] : '0;
        rear_word  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_valid[i] && ((i == DEPTH - 1) || !cell_valid[(i + 1) % DEPTH]))
            begin
                rear_word = rear_word | cell_data[i];
            end
        end
    end

    // request decode
    always_comb
    begin
        ctrl           = '0;
        ctrl.word      = s_tdata;
        count_next     = count_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            popped_next    = '0;
            unique case (op_t'(s_tuser)) inside
                OP_PUSH_FRONT, OP_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        ctrl.push_front = (op_t'(s_tuser) == OP_PUSH_FRONT);
                        ctrl.push_rear  = (op_t'(s_tuser) == OP_PUSH_REAR);
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                OP_POP_FRONT, OP_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.pop_front = (op_t'(s_tuser) == OP_POP_FRONT);
                        ctrl.pop_rear  = (op_t'(s_tuser) == OP_POP_REAR);
                        popped_next    = (op_t'(s_tuser) == OP_POP_FRONT) ?
                                         front_word : rear_word;
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                OP_CLEAR:
                begin
                    ctrl.clear = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    // peek and unused selectors leave the queue alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
    end

    // row of cells; cell 0 sees the incoming word on its left,
    // the last cell sees an empty slot on its right
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic              lv;
        logic [WORD_W-1:0] ld;
        logic              rv;
        logic [WORD_W-1:0] rd;
        if (g == 0)
        begin : g_first
            assign lv = 1'b1;
            assign ld = s_tdata;
        end
        else
        begin : g_mid_l
            assign lv = cell_valid[g-1];
            assign ld = cell_data[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign rv = 1'b0;
            assign rd = '0;
        end
        else
        begin : g_mid_r
            assign rv = cell_valid[g+1];
            assign rd = cell_data[g+1];
        end
        deq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .valid       (cell_valid[g]),
            .data        (cell_data[g])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, status_reg, OCC_W'(count_reg), is_full, is_empty,
                       rear_word, front_word, popped_reg};

endmodule
